>>> src/sit_pkg.sv
// Shared types and constants for the string interning table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package sit_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef enum logic [1:0] {
    RES_FOUND,
    RES_NEW,
    RES_FULL,
    RES_LONG
  } res_sel_e;

  typedef struct packed {
    logic     collect;
    logic     walk_start;
    logic     rd_entry;
    logic     next_entry;
    logic     clr_j;
    logic     rd_bytes;
    logic     append_meta;
    logic     copy_rd;
    logic     copy_wr;
    logic     commit_new;
    logic     load_out;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic too_long;
    logic idx_end;
    logic full;
    logic ent_match;
    logic len_zero;
    logic j_end;
    logic byte_eq;
  } sts_t;

endpackage
`default_nettype wire

>>> src/sit_ctrl.sv
// Controller of the string interning table: sequences collection, the walk
// over stored entries, the append and the result word. Uses sit_pkg.
`default_nettype none
module sit_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          last_i,
  input  wire logic          empty_req_i,
  output logic               in_stall_o,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  input  wire sit_pkg::sts_t sts_i,
  output sit_pkg::cmd_t      cmd_o
);
  import sit_pkg::*;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_CHECK,
    S_ENT,
    S_ENTCMP,
    S_BRD,
    S_BCMP,
    S_APPEND,
    S_CPRD,
    S_CPWR,
    S_RESULT
  } state_e;

  state_e   state_q, state_d;
  res_sel_e res_q, res_d;
  logic     out_valid_q;
  logic     accept;

  assign in_stall_o  = (state_q != S_COLLECT);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == S_COLLECT);

  always_comb begin
    cmd_o         = '0;
    cmd_o.res_sel = res_q;
    state_d       = state_q;
    res_d         = res_q;
    case (state_q)
      S_COLLECT: begin
        cmd_o.collect = accept;
        if (accept && (last_i || empty_req_i)) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.too_long) begin
          res_d   = RES_LONG;
          state_d = S_RESULT;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_ENT;
        end
      end
      S_ENT: begin
        if (sts_i.idx_end) begin
          if (sts_i.full) begin
            res_d   = RES_FULL;
            state_d = S_RESULT;
          end else begin
            state_d = S_APPEND;
          end
        end else begin
          cmd_o.rd_entry = 1'b1;
          state_d        = S_ENTCMP;
        end
      end
      S_ENTCMP: begin
        if (sts_i.ent_match) begin
          if (sts_i.len_zero) begin
            res_d   = RES_FOUND;
            state_d = S_RESULT;
          end else begin
            cmd_o.clr_j = 1'b1;
            state_d     = S_BRD;
          end
        end else begin
          cmd_o.next_entry = 1'b1;
          state_d          = S_ENT;
        end
      end
      S_BRD: begin
        if (sts_i.j_end) begin
          res_d   = RES_FOUND;
          state_d = S_RESULT;
        end else begin
          cmd_o.rd_bytes = 1'b1;
          state_d        = S_BCMP;
        end
      end
      S_BCMP: begin
        if (sts_i.byte_eq) begin
          state_d = S_BRD;
        end else begin
          cmd_o.next_entry = 1'b1;
          state_d          = S_ENT;
        end
      end
      S_APPEND: begin
        cmd_o.append_meta = 1'b1;
        cmd_o.clr_j       = 1'b1;
        state_d           = S_CPRD;
      end
      S_CPRD: begin
        if (sts_i.j_end) begin
          res_d   = RES_NEW;
          state_d = S_RESULT;
        end else begin
          cmd_o.copy_rd = 1'b1;
          state_d       = S_CPWR;
        end
      end
      S_CPWR: begin
        cmd_o.copy_wr = 1'b1;
        state_d       = S_CPRD;
      end
      S_RESULT: begin
        // The previous result word must have left before this one is loaded.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.commit_new = (res_q == RES_NEW);
          state_d          = S_COLLECT;
        end
      end
      default: state_d = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_COLLECT;
      res_q       <= RES_FOUND;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      if (cmd_o.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> src/sit_dp.sv
// Datapath of the string interning table: hash and length accumulators,
// the pending byte buffer, the entry memories and the result registers. Uses sit_pkg.
`default_nettype none
module sit_dp #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_LENGTH  = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          empty_req_i,
  input  wire sit_pkg::cmd_t cmd_i,
  output sit_pkg::sts_t      sts_o,
  output logic [7:0]         entry_index_o,
  output logic               is_new_o,
  output logic [1:0]         status_o
);
  import sit_pkg::*;

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
  localparam int LENW  = $clog2(MAX_LENGTH + 1);
  localparam int LW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int BDEPTH = MAX_ENTRIES * (2 ** LW);

  logic [31:0]     hash_q, hash_d;
  logic [LENW-1:0] len_q, len_d;
  logic            too_long_q, too_long_d;
  logic [CNTW-1:0] count_q, idx_q, j_ext;
  logic [LENW-1:0] j_q;
  logic [LW-1:0]   wj_q;
  logic [31:0]     hm_q;
  logic [LENW-1:0] lm_q;
  logic [7:0]      pb_q, sb_q;
  logic [31:0]     idx_wide, cnt_wide;
  logic            room;

  logic [7:0]      pend_mem [MAX_LENGTH];
  logic [31:0]     hash_mem [MAX_ENTRIES];
  logic [LENW-1:0] len_mem  [MAX_ENTRIES];
  logic [7:0]      byte_mem [BDEPTH];

  assign room  = (len_q < LENW'(MAX_LENGTH));
  assign j_ext = '0;

  always_comb begin
    hash_d     = hash_q;
    len_d      = len_q;
    too_long_d = too_long_q;
    if (cmd_i.collect && !empty_req_i) begin
      if (room) begin
        hash_d = 32'((hash_q ^ {24'd0, data_byte_i}) * FNV_PRIME);
        len_d  = len_q + LENW'(1);
      end else begin
        too_long_d = 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      hash_d     = FNV_BASIS;
      len_d      = '0;
      too_long_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q     <= FNV_BASIS;
      len_q      <= '0;
      too_long_q <= 1'b0;
      count_q    <= '0;
      idx_q      <= '0;
      j_q        <= '0;
    end else begin
      hash_q     <= hash_d;
      len_q      <= len_d;
      too_long_q <= too_long_d;
      if (cmd_i.commit_new) count_q <= count_q + CNTW'(1);
      if (cmd_i.walk_start) idx_q <= j_ext;
      else if (cmd_i.next_entry) idx_q <= idx_q + CNTW'(1);
      if (cmd_i.clr_j) j_q <= '0;
      else if (cmd_i.rd_bytes || cmd_i.copy_rd) j_q <= j_q + LENW'(1);
    end
  end

  // Pending buffer: written while collecting, read for compare and copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.collect && !empty_req_i && room) pend_mem[len_q[LW-1:0]] <= data_byte_i;
    if (cmd_i.rd_bytes || cmd_i.copy_rd) pb_q <= pend_mem[j_q[LW-1:0]];
    if (cmd_i.copy_rd) wj_q <= j_q[LW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append_meta) begin
      hash_mem[count_q[AW-1:0]] <= hash_q;
      len_mem[count_q[AW-1:0]]  <= len_q;
    end
    if (cmd_i.rd_entry) begin
      hm_q <= hash_mem[idx_q[AW-1:0]];
      lm_q <= len_mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr) byte_mem[{count_q[AW-1:0], wj_q}] <= pb_q;
    if (cmd_i.rd_bytes) sb_q <= byte_mem[{idx_q[AW-1:0], j_q[LW-1:0]}];
  end

  assign sts_o.too_long  = too_long_q;
  assign sts_o.idx_end   = (idx_q == count_q);
  assign sts_o.full      = (count_q == CNTW'(MAX_ENTRIES));
  assign sts_o.ent_match = (hm_q == hash_q) && (lm_q == len_q);
  assign sts_o.len_zero  = (len_q == '0);
  assign sts_o.j_end     = (j_q == len_q);
  assign sts_o.byte_eq   = (pb_q == sb_q);

  assign idx_wide = 32'(idx_q);
  assign cnt_wide = 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (cmd_i.res_sel)
        RES_FOUND: begin
          entry_index_o <= idx_wide[7:0];
          is_new_o      <= 1'b0;
          status_o      <= ST_OK;
        end
        RES_NEW: begin
          entry_index_o <= cnt_wide[7:0];
          is_new_o      <= 1'b1;
          status_o      <= ST_OK;
        end
        RES_FULL: begin
          entry_index_o <= 8'd0;
          is_new_o      <= 1'b0;
          status_o      <= ST_FULL;
        end
        default: begin
          entry_index_o <= 8'd0;
          is_new_o      <= 1'b0;
          status_o      <= ST_TOO_LONG;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/string_interning_table_core.sv
// String interning table: FNV-1a hashed byte strings, one byte per word.
// Throughput: one byte word per cycle while a string is collected.
// End of string: a check, then a walk over stored entries (read, compare), a byte
// compare on a match; a miss appends the entry and copies its bytes; then the load.
// The entry walk reads the entry memories; the copy reads the pending buffer into the byte memory.
// Reset clears counters and control at once; memories need no clearing pass.
`default_nettype none
module string_interning_table_core #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_LENGTH  = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  input  wire logic       empty_req_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      entry_index_o,
  output logic            is_new_o,
  output logic [1:0]      status_o
);
  import sit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sit_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .last_i,
    .empty_req_i,
    .in_stall_o,
    .out_stall_i,
    .out_valid_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  sit_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .data_byte_i,
    .empty_req_i,
    .cmd_i (cmd),
    .sts_o (sts),
    .entry_index_o,
    .is_new_o,
    .status_o
  );

endmodule
`default_nettype wire

>>> src/sit_checker.sv
// Port-level checks for the string interning table, bound to the top level.
// Depends on string_interning_table_core's port names and on sit_pkg.
`default_nettype none
module sit_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] entry_index_o,
  input wire logic       is_new_o,
  input wire logic [1:0] status_o
);
  import sit_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_index_o)
      && $stable(is_new_o) && $stable(status_o))
    else $error("result word changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FULL
      || status_o == ST_TOO_LONG))
    else $error("undefined status code");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> !is_new_o && entry_index_o == 8'd0)
    else $error("error result carries an index or new flag");

  a_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_new_o |-> status_o == ST_OK)
    else $error("new entry reported with error status");

endmodule

bind string_interning_table_core sit_checker u_sit_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_stall_i,
  .entry_index_o,
  .is_new_o,
  .status_o
);
`default_nettype wire
